// File: hdl/ntsm_pkg.sv
// Package for the nearest-template SSD matcher: widths, constants and the
// word types shared by the top level and the accumulator. No dependencies.
package ntsm_pkg;

    localparam int MAX_RECORDS = 16;
    localparam int SAMPLE_BITS = 10;

    localparam int VALUE_W   = 10;
    localparam int INDEX_W   = 4;
    localparam int ERROR_W   = 32;
    localparam int SQ_W      = 2 * VALUE_W;
    localparam int COUNT_W   = $clog2(MAX_RECORDS + 1);
    localparam int IDX_EXT_W = (COUNT_W > INDEX_W) ? COUNT_W : INDEX_W;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_USER_W = 2;

    localparam logic [ERROR_W-1:0] SUM_MAX = {ERROR_W{1'b1}};
    localparam logic [VALUE_W-1:0] SAMPLE_MASK =
        VALUE_W'((64'd1 << SAMPLE_BITS) - 64'd1);

    typedef struct packed {
        logic [VALUE_W-1:0] template_value;
        logic [VALUE_W-1:0] live_value;
        logic               end_of_record;
        logic               end_of_query;
    } item_t;

    typedef struct packed {
        logic [INDEX_W-1:0] best_index;
        logic [ERROR_W-1:0] best_error;
        logic               no_records;
        logic               overflowed;
    } result_t;

endpackage

// File: hdl/ntsm_accum.sv
// Square-and-accumulate datapath with best-record tracking and query state.
// Depends on ntsm_pkg.
module ntsm_accum
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  ntsm_pkg::item_t item,
    output ntsm_pkg::result_t res
);

    logic [ntsm_pkg::ERROR_W-1:0] running_sum_reg, running_sum_next;
    logic [ntsm_pkg::ERROR_W-1:0] best_sum_reg, best_sum_next;
    logic [ntsm_pkg::COUNT_W-1:0] best_record_reg, best_record_next;
    logic [ntsm_pkg::COUNT_W-1:0] record_count_reg, record_count_next;
    logic                         overflow_seen_reg, overflow_seen_next;

    logic [ntsm_pkg::VALUE_W-1:0]   t_val, l_val, diff;
    logic [ntsm_pkg::SQ_W-1:0]      sq;
    logic [ntsm_pkg::ERROR_W:0]     sum_wide;
    logic [ntsm_pkg::ERROR_W-1:0]   sum_sat;
    logic [ntsm_pkg::ERROR_W-1:0]   best_sum_upd;
    logic [ntsm_pkg::COUNT_W-1:0]   best_record_upd, record_count_upd;
    logic                           overflow_upd;
    logic [ntsm_pkg::IDX_EXT_W-1:0] best_record_ext;

    always_comb
    begin
        t_val    = item.template_value & ntsm_pkg::SAMPLE_MASK;
        l_val    = item.live_value & ntsm_pkg::SAMPLE_MASK;
        diff     = (t_val >= l_val) ? (t_val - l_val) : (l_val - t_val);
        sq       = ntsm_pkg::SQ_W'(diff) * ntsm_pkg::SQ_W'(diff);
        sum_wide = {1'b0, running_sum_reg} + (ntsm_pkg::ERROR_W + 1)'(sq);
        sum_sat  = sum_wide[ntsm_pkg::ERROR_W] ? ntsm_pkg::SUM_MAX
                                               : sum_wide[ntsm_pkg::ERROR_W-1:0];

        best_sum_upd     = best_sum_reg;
        best_record_upd  = best_record_reg;
        record_count_upd = record_count_reg;
        overflow_upd     = overflow_seen_reg;
        running_sum_next = sum_sat;

        if (item.end_of_record)
        begin
            if (record_count_reg >= ntsm_pkg::COUNT_W'(ntsm_pkg::MAX_RECORDS))
            begin
                overflow_upd = 1'b1;
            end
            else
            begin
                // strict less-than: earliest record wins a tie
                if ((record_count_reg == '0) || (sum_sat < best_sum_reg))
                begin
                    best_sum_upd    = sum_sat;
                    best_record_upd = record_count_reg;
                end
                record_count_upd = record_count_reg + 1'b1;
            end
            running_sum_next = '0;
        end

        best_sum_next      = best_sum_upd;
        best_record_next   = best_record_upd;
        record_count_next  = record_count_upd;
        overflow_seen_next = overflow_upd;

        // query closes: back to the reset state
        if (item.end_of_query)
        begin
            running_sum_next   = '0;
            best_sum_next      = ntsm_pkg::SUM_MAX;
            best_record_next   = '0;
            record_count_next  = '0;
            overflow_seen_next = 1'b0;
        end

        best_record_ext = ntsm_pkg::IDX_EXT_W'(best_record_upd);
        res.no_records  = (record_count_upd == '0);
        res.overflowed  = overflow_upd;
        res.best_index  = res.no_records ? '0 : best_record_ext[ntsm_pkg::INDEX_W-1:0];
        res.best_error  = res.no_records ? ntsm_pkg::SUM_MAX : best_sum_upd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_sum_reg   <= '0;
            best_sum_reg      <= ntsm_pkg::SUM_MAX;
            best_record_reg   <= '0;
            record_count_reg  <= '0;
            overflow_seen_reg <= 1'b0;
        end
        else if (step)
        begin
            running_sum_reg   <= running_sum_next;
            best_sum_reg      <= best_sum_next;
            best_record_reg   <= best_record_next;
            record_count_reg  <= record_count_next;
            overflow_seen_reg <= overflow_seen_next;
        end
    end

endmodule

// File: hdl/nearest_template_ssd_match.sv
// Top level of the nearest-template SSD matcher: input word register, the
// accumulator and the result register. Depends on ntsm_pkg and ntsm_accum.
//
// Use:
//   The slave channel takes one word per template element: s_tdata carries
//   the template element and the matching live element, s_tuser flags the
//   last element of a record and s_tlast flags the last word of a query.
//   Each word adds the squared difference (saturating at all ones) to the
//   record's running sum; a closed record is compared with the best so far.
//   On the last word of a query the master channel presents one word with
//   the best record index, its error, a no-records flag and an overflow
//   flag (records beyond the limit are dropped and flagged).
//   Timing: the accepted closing word sits in the input register; when it
//   moves on, the result register loads and m_tvalid rises.
//   Throughput: one word per cycle unless a closing word is held (see Stall),
//   set by the single square-and-add stage feeding the accumulator register.
//   Stall: a waiting result does not block ordinary words; only a further
//   query-closing word waits in the input register until the previous
//   result is taken, and s_tready drops meanwhile.
//   Reset: both registers empty, sums cleared, best error all ones.
module nearest_template_ssd_match
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [9:0] template_value, [19:10] live_value, [23:20] zero
    input  logic [ntsm_pkg::IN_DATA_W-1:0]    s_tdata,
    // [0] end_of_record
    input  logic                              s_tuser,
    input  logic                              s_tlast,   // end_of_query
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [3:0] best_index, [35:4] best_error, [39:36] zero
    output logic [ntsm_pkg::OUT_DATA_W-1:0]   m_tdata,
    // [0] no_records, [1] overflowed
    output logic [ntsm_pkg::OUT_USER_W-1:0]   m_tuser
);

    logic              in_valid_reg, in_valid_next;
    ntsm_pkg::item_t   in_item_reg, in_item_next;
    logic              out_valid_reg, out_valid_next;
    ntsm_pkg::result_t out_res_reg, out_res_next;
    ntsm_pkg::result_t acc_res;
    logic              advance;
    logic              emit;

    // the stage holds only a query-closing word while a result still waits
    assign advance  = in_valid_reg
                      && !(in_item_reg.end_of_query && out_valid_reg && !m_tready);
    assign emit     = advance && in_item_reg.end_of_query;
    assign s_tready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = s_tready ? s_tvalid : in_valid_reg;

        in_item_next                = in_item_reg;
        if (s_tready && s_tvalid)
        begin
            in_item_next.template_value = s_tdata[ntsm_pkg::VALUE_W-1:0];
            in_item_next.live_value     = s_tdata[2*ntsm_pkg::VALUE_W-1:ntsm_pkg::VALUE_W];
            in_item_next.end_of_record  = s_tuser;
            in_item_next.end_of_query   = s_tlast;
        end

        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_res_next   = acc_res;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    ntsm_accum u_accum
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (in_item_reg),
        .res   (acc_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_item_reg <= in_item_next;
        out_res_reg <= out_res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(ntsm_pkg::OUT_DATA_W - ntsm_pkg::ERROR_W - ntsm_pkg::INDEX_W){1'b0}},
                       out_res_reg.best_error, out_res_reg.best_index};
    assign m_tuser  = {out_res_reg.overflowed, out_res_reg.no_records};

    // a query-closing word that moves on always loads the result register
    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> m_tvalid)
        else $error("closing word did not produce a result");

    // back-pressure only while a result waits downstream
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without a waiting result");

    // an empty query reports index zero and an all-ones error
    a_empty_query: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |->
            (m_tdata[ntsm_pkg::INDEX_W-1:0] == '0
             && m_tdata[ntsm_pkg::INDEX_W+ntsm_pkg::ERROR_W-1:ntsm_pkg::INDEX_W]
                == ntsm_pkg::SUM_MAX))
        else $error("empty query result malformed");

endmodule
